### rtl/adst_pkg.sv
// shared constants, types and codes of the adaptive decimating state trace
`default_nettype none

package adst_pkg;

    localparam int THREADS     = 8;
    localparam int LOG_DEPTH   = 64;
    localparam int REDUCTION   = 2;
    localparam int STATE_COUNT = 4;

    // fixed field widths of the channels
    localparam int TID_W   = 3;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int CAP_W   = 32;
    localparam int START_W = 7;

    localparam int TIDX_W     = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LOG_AW     = $clog2(LOG_DEPTH);
    localparam int CODE_SLOTS = 4;
    localparam int CNT_DEPTH  = THREADS * CODE_SLOTS;
    localparam int CNT_AW     = TIDX_W + STAT_W;
    localparam int VOTE_W     = $clog2(REDUCTION + 1);
    localparam int MERGE_ROWS = (LOG_DEPTH + REDUCTION - 1) / REDUCTION;
    localparam int MERGED_END = LOG_DEPTH / REDUCTION;

    // start / REDUCTION as a multiply by a scaled reciprocal
    localparam int DIV_SHIFT = LOG_AW + 3;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + REDUCTION - 1) / REDUCTION;
    localparam int DIV_PROD_W = LOG_AW + DIV_SHIFT + 1;

    localparam logic [CAP_W-1:0] CAP_SAT_LIMIT = 32'hFFFF_FFFF / REDUCTION;

    localparam logic [STAT_W-1:0] STATUS_UNREGISTERED = 2'd0;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef logic [THREADS-1:0][STAT_W-1:0] t_row;

    typedef struct packed {
        logic              rd_en;
        logic [LOG_AW-1:0] rd_addr;
        logic              wr_en;
        logic [LOG_AW-1:0] wr_addr;
        t_row              wr_data;
    } t_log_req;

endpackage

`default_nettype wire

### rtl/adst_if.sv
// valid/ready channels of the trace unit: item in, result out
`default_nettype none

interface adst_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [adst_pkg::TID_W-1:0]  thread_id;
    logic [adst_pkg::STAT_W-1:0] status;
    logic                        sample_end;
    logic [adst_pkg::POS_W-1:0]  position;

    modport source (output valid, action, thread_id, status, sample_end, position,
                    input ready);
    modport sink   (input valid, action, thread_id, status, sample_end, position,
                    output ready);
endinterface

interface adst_out_if;
    logic                                valid;
    logic                                ready;
    logic [adst_pkg::STAT_W-1:0]         read_status;
    logic [adst_pkg::POS_W-1:0]          log_end;
    logic [adst_pkg::CAP_W-1:0]          sample_capacity;
    logic signed [adst_pkg::START_W-1:0] thread_start;
    logic                                entry_committed;
    logic                                log_merged;

    modport source (output valid, read_status, log_end, sample_capacity, thread_start,
                    entry_committed, log_merged, input ready);
    modport sink   (input valid, read_status, log_end, sample_capacity, thread_start,
                    entry_committed, log_merged, output ready);
endinterface

`default_nettype wire

### rtl/adst_log_mem.sv
// trace log memory: one row of thread statuses per position, row valid bits for reset
`default_nettype none

module adst_log_mem (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire adst_pkg::t_log_req i_req,
    output adst_pkg::t_row          o_rd_data
);

    adst_pkg::t_row              mem [adst_pkg::LOG_DEPTH];
    logic [adst_pkg::LOG_DEPTH-1:0] r_row_valid;
    adst_pkg::t_row              r_rd_data;
    logic                        r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
            r_rd_hit  <= r_row_valid[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_req.wr_en) begin
            r_row_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // a row never written reads as unregistered for every thread
    assign o_rd_data = r_rd_hit ? r_rd_data
                                : {adst_pkg::THREADS{adst_pkg::STATUS_UNREGISTERED}};

endmodule

`default_nettype wire

### rtl/adaptive_decimating_state_trace_unit.sv
// top level: sequencer, vote counters and shared compare unit of the state trace
// read: log row read, then result; record: count read and increment, then result or tick
// commit at capacity: row read, count read and compare per thread and code, then row write
// merge on a full log: per merged row, up to REDUCTION row reads, a target read and a write
// one item at a time; ready is high only while no item is at work
// sync active-low reset; counts and log clear at once through valid bits, no sweep
`default_nettype none

module adaptive_decimating_state_trace_unit (
    input  wire            i_clk,
    input  wire            i_rst_n,
    adst_in_if.sink        i_in,
    adst_out_if.source     o_out
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_READ    = 5'd1;
    localparam logic [4:0] S_READ_D  = 5'd2;
    localparam logic [4:0] S_REC     = 5'd3;
    localparam logic [4:0] S_REC_INC = 5'd4;
    localparam logic [4:0] S_TICK    = 5'd5;
    localparam logic [4:0] S_C_ROW   = 5'd6;
    localparam logic [4:0] S_C_ROWD  = 5'd7;
    localparam logic [4:0] S_C_RD    = 5'd8;
    localparam logic [4:0] S_C_CMP   = 5'd9;
    localparam logic [4:0] S_C_WR    = 5'd10;
    localparam logic [4:0] S_M_RD    = 5'd11;
    localparam logic [4:0] S_M_ACC   = 5'd12;
    localparam logic [4:0] S_M_TGT   = 5'd13;
    localparam logic [4:0] S_M_WR    = 5'd14;
    localparam logic [4:0] S_M_FIN   = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    typedef logic [adst_pkg::CODE_SLOTS-1:0][adst_pkg::VOTE_W-1:0] t_votes;

    function automatic logic [adst_pkg::STAT_W-1:0] vote_major(input t_votes v);
        logic [adst_pkg::STAT_W-1:0] best;
        best = '0;
        for (int j = 1; j < adst_pkg::STATE_COUNT; j++) begin
            if (v[j] > v[best]) begin
                best = adst_pkg::STAT_W'(j);
            end
        end
        return best;
    endfunction

    logic [4:0]                         r_state, n_state;
    logic                               r_action, n_action;
    logic [adst_pkg::TID_W-1:0]         r_tid, n_tid;
    logic [adst_pkg::STAT_W-1:0]        r_status, n_status;
    logic                               r_end, n_end;
    logic [adst_pkg::POS_W-1:0]         r_pos, n_pos;

    logic [adst_pkg::CAP_W-1:0]         r_ticks, n_ticks;
    logic [adst_pkg::CAP_W-1:0]         r_tpe, n_tpe;
    logic [adst_pkg::LOG_AW-1:0]        r_next_pos, n_next_pos;
    logic signed [adst_pkg::START_W-1:0] r_first [adst_pkg::THREADS];
    logic signed [adst_pkg::START_W-1:0] n_first [adst_pkg::THREADS];

    logic [adst_pkg::TIDX_W-1:0]        r_t, n_t;
    logic [adst_pkg::STAT_W-1:0]        r_j, n_j;
    logic [adst_pkg::STAT_W-1:0]        r_best, n_best;
    logic [adst_pkg::CAP_W-1:0]         r_best_cnt, n_best_cnt;
    adst_pkg::t_row                     r_row, n_row;

    logic [adst_pkg::LOG_AW-1:0]        r_k, n_k;
    logic [adst_pkg::LOG_AW-1:0]        r_base, n_base;
    logic [adst_pkg::VOTE_W-1:0]        r_mj, n_mj;
    t_votes                             r_votes [adst_pkg::THREADS];
    t_votes                             n_votes [adst_pkg::THREADS];

    logic [adst_pkg::STAT_W-1:0]        r_rstat, n_rstat;
    logic                               r_committed, n_committed;
    logic                               r_merged, n_merged;

    logic                               r_out_valid;
    logic [adst_pkg::STAT_W-1:0]        r_out_rstat;
    logic [adst_pkg::POS_W-1:0]         r_out_end;
    logic [adst_pkg::CAP_W-1:0]         r_out_cap;
    logic signed [adst_pkg::START_W-1:0] r_out_start;
    logic                               r_out_committed;
    logic                               r_out_merged;
    logic                               out_load;

    // vote counter memory
    logic [adst_pkg::CAP_W-1:0]         cnt_mem [adst_pkg::CNT_DEPTH];
    logic [adst_pkg::CNT_DEPTH-1:0]     r_cnt_valid;
    logic [adst_pkg::CAP_W-1:0]         r_cnt_q;
    logic                               r_cnt_hit;
    logic                               cnt_rd_en;
    logic                               cnt_wr_en;
    logic                               cnt_clear;
    logic [adst_pkg::CNT_AW-1:0]        cnt_addr;
    logic [adst_pkg::CAP_W-1:0]         cnt_wr_data;
    logic [adst_pkg::CAP_W-1:0]         cnt_val;

    adst_pkg::t_log_req                 log_req;
    adst_pkg::t_row                     log_rd;

    logic                               in_acc;
    logic                               tid_ok;
    logic                               pos_ok;
    logic                               stat_ok;
    logic [adst_pkg::TIDX_W-1:0]        tid_idx;
    logic [adst_pkg::THREADS-1:0]       started;
    logic [adst_pkg::CAP_W-1:0]         tick_inc;
    logic [adst_pkg::STAT_W-1:0]        cmp_code;
    logic [adst_pkg::LOG_AW:0]          pos_inc;
    logic [adst_pkg::VOTE_W-1:0]        mj_next;
    logic [adst_pkg::LOG_AW:0]          row_next;
    logic [adst_pkg::DIV_PROD_W-1:0]    div_prod [adst_pkg::THREADS];

    adst_log_mem u_log_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (log_req),
        .o_rd_data (log_rd)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign tid_ok   = 32'(r_tid) < adst_pkg::THREADS;
    assign pos_ok   = 32'(r_pos) < adst_pkg::LOG_DEPTH;
    assign stat_ok  = 32'(r_status) < adst_pkg::STATE_COUNT;
    assign tid_idx  = adst_pkg::TIDX_W'(r_tid);
    assign cnt_val  = r_cnt_hit ? r_cnt_q : '0;
    assign tick_inc = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;
    assign pos_inc  = {1'b0, r_next_pos} + 1'b1;
    assign mj_next  = r_mj + 1'b1;
    assign row_next = {1'b0, r_base} + (adst_pkg::LOG_AW + 1)'(mj_next);

    always_comb begin
        for (int t = 0; t < adst_pkg::THREADS; t++) begin
            started[t]  = !r_first[t][adst_pkg::START_W-1];
            div_prod[t] = adst_pkg::DIV_PROD_W'(r_first[t][adst_pkg::LOG_AW-1:0])
                        * adst_pkg::DIV_PROD_W'(adst_pkg::DIV_RECIP);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_tid       = r_tid;
        n_status    = r_status;
        n_end       = r_end;
        n_pos       = r_pos;
        n_ticks     = r_ticks;
        n_tpe       = r_tpe;
        n_next_pos  = r_next_pos;
        n_first     = r_first;
        n_t         = r_t;
        n_j         = r_j;
        n_best      = r_best;
        n_best_cnt  = r_best_cnt;
        n_row       = r_row;
        n_k         = r_k;
        n_base      = r_base;
        n_mj        = r_mj;
        n_votes     = r_votes;
        n_rstat     = r_rstat;
        n_committed = r_committed;
        n_merged    = r_merged;
        out_load    = 1'b0;
        log_req     = '0;
        cnt_rd_en   = 1'b0;
        cnt_wr_en   = 1'b0;
        cnt_clear   = 1'b0;
        cnt_addr    = {tid_idx, r_status};
        cnt_wr_data = (cnt_val == '1) ? cnt_val : cnt_val + 1'b1;
        cmp_code    = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action    = i_in.action;
                    n_tid       = i_in.thread_id;
                    n_status    = i_in.status;
                    n_end       = i_in.sample_end;
                    n_pos       = i_in.position;
                    n_rstat     = '0;
                    n_committed = 1'b0;
                    n_merged    = 1'b0;
                    n_state     = (i_in.action == adst_pkg::ACT_READ) ? S_READ : S_REC;
                end
            end
            S_READ: begin
                log_req.rd_en   = 1'b1;
                log_req.rd_addr = adst_pkg::LOG_AW'(r_pos);
                n_state         = S_READ_D;
            end
            S_READ_D: begin
                if (tid_ok && pos_ok) begin
                    n_rstat = log_rd[tid_idx];
                end
                n_state = S_DONE;
            end
            S_REC: begin
                if (tid_ok && !started[tid_idx]) begin
                    n_first[tid_idx] = $signed(adst_pkg::START_W'(r_next_pos));
                end
                cnt_rd_en = 1'b1;
                n_state   = S_REC_INC;
            end
            S_REC_INC: begin
                cnt_wr_en = tid_ok && stat_ok;
                n_state   = r_end ? S_TICK : S_DONE;
            end
            S_TICK: begin
                n_ticks = tick_inc;
                n_state = (tick_inc >= r_tpe) ? S_C_ROW : S_DONE;
            end
            S_C_ROW: begin
                log_req.rd_en   = 1'b1;
                log_req.rd_addr = r_next_pos;
                n_state         = S_C_ROWD;
            end
            S_C_ROWD: begin
                n_row   = log_rd;
                n_t     = '0;
                n_j     = '0;
                n_state = S_C_RD;
            end
            S_C_RD: begin
                cnt_rd_en = 1'b1;
                cnt_addr  = {r_t, r_j};
                n_state   = S_C_CMP;
            end
            S_C_CMP: begin
                // shared compare: strictly greater keeps ties on the lower code
                if (r_j == '0 || cnt_val > r_best_cnt) begin
                    n_best     = r_j;
                    n_best_cnt = cnt_val;
                    cmp_code   = r_j;
                end
                if (r_j == adst_pkg::STAT_W'(adst_pkg::STATE_COUNT - 1)) begin
                    if (started[r_t]) begin
                        n_row[r_t] = cmp_code;
                    end
                    n_j = '0;
                    if (r_t == adst_pkg::TIDX_W'(adst_pkg::THREADS - 1)) begin
                        n_state = S_C_WR;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = S_C_RD;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_C_RD;
                end
            end
            S_C_WR: begin
                log_req.wr_en   = 1'b1;
                log_req.wr_addr = r_next_pos;
                log_req.wr_data = r_row;
                cnt_clear       = 1'b1;
                n_ticks         = '0;
                n_committed     = 1'b1;
                if (32'(pos_inc) >= adst_pkg::LOG_DEPTH) begin
                    n_k    = '0;
                    n_base = '0;
                    n_mj   = '0;
                    for (int t = 0; t < adst_pkg::THREADS; t++) begin
                        n_votes[t] = '0;
                    end
                    n_state = S_M_RD;
                end else begin
                    n_next_pos = adst_pkg::LOG_AW'(pos_inc);
                    n_state    = S_DONE;
                end
            end
            S_M_RD: begin
                log_req.rd_en   = 1'b1;
                log_req.rd_addr = r_base + adst_pkg::LOG_AW'(r_mj);
                n_state         = S_M_ACC;
            end
            S_M_ACC: begin
                for (int t = 0; t < adst_pkg::THREADS; t++) begin
                    n_votes[t][log_rd[t]] = r_votes[t][log_rd[t]] + 1'b1;
                end
                // partial last block stops at the end of the log
                if (32'(mj_next) < adst_pkg::REDUCTION
                        && 32'(row_next) < adst_pkg::LOG_DEPTH) begin
                    n_mj    = mj_next;
                    n_state = S_M_RD;
                end else begin
                    n_state = S_M_TGT;
                end
            end
            S_M_TGT: begin
                log_req.rd_en   = 1'b1;
                log_req.rd_addr = r_k;
                n_state         = S_M_WR;
            end
            S_M_WR: begin
                log_req.wr_en   = 1'b1;
                log_req.wr_addr = r_k;
                for (int t = 0; t < adst_pkg::THREADS; t++) begin
                    log_req.wr_data[t] = started[t] ? vote_major(r_votes[t]) : log_rd[t];
                    n_votes[t]         = '0;
                end
                n_mj   = '0;
                n_base = adst_pkg::LOG_AW'({1'b0, r_base}
                                           + (adst_pkg::LOG_AW + 1)'(adst_pkg::REDUCTION));
                n_k    = r_k + 1'b1;
                if (32'(r_k) == adst_pkg::MERGE_ROWS - 1) begin
                    n_state = S_M_FIN;
                end else begin
                    n_state = S_M_RD;
                end
            end
            S_M_FIN: begin
                for (int t = 0; t < adst_pkg::THREADS; t++) begin
                    if (started[t]) begin
                        n_first[t] = $signed(div_prod[t][adst_pkg::DIV_PROD_W-1:
                                                         adst_pkg::DIV_SHIFT]);
                    end
                end
                n_next_pos = adst_pkg::LOG_AW'(adst_pkg::MERGED_END);
                n_tpe      = (r_tpe > adst_pkg::CAP_SAT_LIMIT) ? '1
                           : adst_pkg::CAP_W'(r_tpe * adst_pkg::CAP_W'(adst_pkg::REDUCTION));
                n_merged   = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ticks    <= '0;
            r_tpe      <= adst_pkg::CAP_W'(1);
            r_next_pos <= '0;
            for (int t = 0; t < adst_pkg::THREADS; t++) begin
                r_first[t] <= '1;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ticks    <= n_ticks;
            r_tpe      <= n_tpe;
            r_next_pos <= n_next_pos;
            r_first    <= n_first;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_tid       <= n_tid;
        r_status    <= n_status;
        r_end       <= n_end;
        r_pos       <= n_pos;
        r_t         <= n_t;
        r_j         <= n_j;
        r_best      <= n_best;
        r_best_cnt  <= n_best_cnt;
        r_row       <= n_row;
        r_k         <= n_k;
        r_base      <= n_base;
        r_mj        <= n_mj;
        r_votes     <= n_votes;
        r_rstat     <= n_rstat;
        r_committed <= n_committed;
        r_merged    <= n_merged;
        if (out_load) begin
            r_out_rstat     <= (r_action == adst_pkg::ACT_READ) ? r_rstat : '0;
            r_out_end       <= adst_pkg::POS_W'(r_next_pos);
            r_out_cap       <= r_tpe;
            r_out_start     <= tid_ok ? r_first[tid_idx] : '1;
            r_out_committed <= r_committed;
            r_out_merged    <= r_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_wr_en) begin
            cnt_mem[cnt_addr] <= cnt_wr_data;
        end
        if (cnt_rd_en) begin
            r_cnt_q   <= cnt_mem[cnt_addr];
            r_cnt_hit <= r_cnt_valid[cnt_addr];
        end
    end

    // clearing the valid bits zeroes every counter at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= '0;
        end else if (cnt_clear) begin
            r_cnt_valid <= '0;
        end else if (cnt_wr_en) begin
            r_cnt_valid[cnt_addr] <= 1'b1;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.read_status     = r_out_rstat;
    assign o_out.log_end         = r_out_end;
    assign o_out.sample_capacity = r_out_cap;
    assign o_out.thread_start    = r_out_start;
    assign o_out.entry_committed = r_out_committed;
    assign o_out.log_merged      = r_out_merged;

endmodule

`default_nettype wire

### rtl/adst_checker.sv
// port-level checks of the trace unit and their bind to the top level
`default_nettype none

module adst_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_in_valid,
    input wire                                i_in_ready,
    input wire                                i_out_valid,
    input wire                                i_out_ready,
    input wire [adst_pkg::POS_W-1:0]          i_log_end,
    input wire [adst_pkg::CAP_W-1:0]          i_capacity,
    input wire                                i_committed,
    input wire                                i_merged
);

    // one item at a time: busy right after a transaction on the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready stayed high after a transaction");

    // a merge only follows a commit, resets the end and grows the capacity
    a_merge_effects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_merged) |-> (i_committed && i_capacity != 32'd1
            && 32'(i_log_end) == adst_pkg::MERGED_END))
        else $error("merge result inconsistent");

    a_capacity_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_capacity != '0)
        else $error("sample capacity reported as zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_capacity)
            && $stable(i_log_end)))
        else $error("stalled result changed");

endmodule

bind adaptive_decimating_state_trace_unit adst_checker u_adst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_log_end   (o_out.log_end),
    .i_capacity  (o_out.sample_capacity),
    .i_committed (o_out.entry_committed),
    .i_merged    (o_out.log_merged)
);

`default_nettype wire
